[design/gfe_pkg.sv]
// ----------------------------------------------------------------------------
// gfe_pkg: shared definitions for the glyph frame-buffer engine
// Default geometry, function codes, controller command bytes, sequencer
// states and the 5x8 font table with its character-code mapping.
// ----------------------------------------------------------------------------
package gfe_pkg;

  localparam int DEF_WIDTH_PX   = 128;
  localparam int DEF_PAGE_COUNT = 8;

  localparam int WORD_W     = 64;
  localparam int GLYPH_W    = 40;
  localparam int CMD_COUNT  = 6;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Controller addressing commands sent ahead of each page.
  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] COL_START     = 8'h00;

  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd127;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;
  localparam int         GLYPH_COUNT   = 89;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_FL_CMD,
    ST_FL_RD,
    ST_FL_DATA
  } state_t;

  // Each entry holds five column bytes, leftmost column in the low byte.
  localparam logic [GLYPH_W-1:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h12_2A_7F_2A_24, 40'h62_64_08_13_23, 40'h50_22_55_49_36, 40'h00_00_03_05_00,
    40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
    40'h00_00_30_50_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h02_04_08_10_20,
    40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
    40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
    40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00, 40'h00_00_36_56_00,
    40'h41_22_14_08_00, 40'h14_14_14_14_14, 40'h00_08_14_22_41, 40'h06_09_51_01_02,
    40'h3E_41_79_49_32, 40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h01_01_01_01_7F,
    40'h7E_01_01_01_7F, 40'h01_09_09_09_7F, 40'h06_09_09_09_7F, 40'h22_41_41_41_3E,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h40_7F_01_01_02, 40'h41_22_14_08_7F,
    40'h40_40_40_40_7F, 40'h7F_02_04_02_7F, 40'h7F_02_0C_02_7F, 40'h3E_41_41_41_3E,
    40'h06_09_09_09_7F, 40'h7A_49_49_41_3E, 40'h46_29_19_09_7F, 40'h32_49_49_49_26,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_20_20_1F, 40'h07_18_60_18_07,
    40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h43_45_49_51_61, 40'h00_00_00_00_00,
    40'h00_00_00_00_00, 40'h00_00_00_00_00, 40'h00_00_00_00_00, 40'h08_08_08_08_08,
    40'h78_54_54_54_20, 40'h38_44_44_44_3F, 40'h20_44_44_44_38, 40'h3F_44_44_44_38,
    40'h08_54_54_54_38, 40'h02_01_09_7E_08, 40'h38_22_54_14_08, 40'h02_04_04_08_3F,
    40'h00_41_7F_41_00, 40'h04_02_3F_02_04, 40'h1C_14_14_14_08, 40'h04_04_3F_04_04,
    40'h20_44_44_38_00, 40'h04_24_2C_34_04, 40'h38_44_7F_00_00, 40'h00_04_08_10_7F,
    40'h00_00_41_7F_41, 40'h00_78_04_04_7C, 40'h00_78_04_04_7C, 40'h38_44_44_44_38,
    40'h00_18_18_18_7C, 40'h44_28_10_28_44, 40'h3C_50_50_50_0C, 40'h44_4C_54_64_44,
    40'h00_00_00_00_00
  };

  // Maps a character code to a font entry: codes outside 32 to 127 show '?',
  // and codes past the end of the table show a blank.
  function automatic logic [6:0] font_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c < FIRST_CODE || c > LAST_CODE) begin
      c = FALLBACK_CODE;
    end
    c = c - FIRST_CODE;
    if (int'(c) >= GLYPH_COUNT) begin
      c = 8'd0;
    end
    return c[6:0];
  endfunction

endpackage

[design/gfe_ram.sv]
// ----------------------------------------------------------------------------
// gfe_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module gfe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/glyph_framebuffer_engine_top.sv]
// ----------------------------------------------------------------------------
// glyph_framebuffer_engine_top: page-organized monochrome frame store
// Clears the store, draws clipped 5x8 glyphs into it and streams one page
// at a time as controller command bytes followed by packed column words.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_ready | func, x_pos, y_pos, char_code,
//          |           |                     | page_sel
//  out     | output    | out_valid/out_ready | kind, value, last
//
// A draw visits all four candidate words (two pages by two word columns);
// a word off the screen is skipped, and one that lies on the screen is
// updated by a read-modify-write through the single store port pair.
// A clear writes zero to all WIDTH_PX*PAGE_COUNT/8 words (128 by default), one word a cycle.
// A flush sends 6 command bytes, then reads and sends each data word of
// the page in turn; a stall of the output holds the sequence in place.
// After reset the same one-word-a-cycle clearing pass runs before the
// first input transfer is taken.
//
module glyph_framebuffer_engine_top #(
  parameter int WIDTH_PX   = gfe_pkg::DEF_WIDTH_PX,
  parameter int PAGE_COUNT = gfe_pkg::DEF_PAGE_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic signed [8:0] x_pos,
  input  logic signed [8:0] y_pos,
  input  logic [7:0]        char_code,
  input  logic [2:0]        page_sel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [63:0]       value,
  output logic              last
);

  import gfe_pkg::*;

  localparam int WordsPerPage = WIDTH_PX / 8;
  localparam int StoreWords   = WordsPerPage * PAGE_COUNT;
  localparam int AW           = $clog2(StoreWords);
  localparam int WW           = $clog2(WordsPerPage);

  state_t state, state_next;

  // Control registers.
  logic [AW-1:0] clr_cnt;
  logic [1:0]    tgt;
  logic [2:0]    cmd_idx;
  logic [WW-1:0] wcnt;

  // Item registers, loaded on each input transfer.
  logic [GLYPH_W-1:0] glyph;
  logic signed [8:0]  x_r;
  logic signed [8:0]  y_r;
  logic signed [6:0]  p0;
  logic signed [6:0]  w0;
  logic [2:0]         page_r;

  // Store port signals.
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  // Output register load.
  logic              out_load;
  logic              kind_next;
  logic [WORD_W-1:0] value_next;
  logic              last_next;

  logic              accept;
  logic              slot_free;
  logic              page_ok;
  logic signed [6:0] pg;
  logic signed [6:0] wc;
  logic              tgt_ok;
  logic [AW-1:0]     draw_addr;
  logic [AW-1:0]     flush_addr;
  logic              last_word;
  logic [7:0]        cmd_byte;

  gfe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (StoreWords)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The shared mask unit: for one store word (page pg, word column wc) it
  // builds the 64-bit set of glyph pixels that land in that word. Every
  // column byte and row bit is tested on its own, so clipping falls out of
  // only ever visiting words that exist on the screen.
  function automatic logic [WORD_W-1:0] build_mask(
    input logic [GLYPH_W-1:0] g,
    input logic signed [8:0]  x,
    input logic signed [8:0]  y,
    input logic signed [6:0]  pgv,
    input logic signed [6:0]  wcv
  );
    logic [WORD_W-1:0] m;
    logic [7:0]        colb;
    logic [2:0]        di;
    int                dx;
    int                j;
    m = '0;
    for (int c = 0; c < 8; c++) begin
      dx   = int'(wcv) * 8 + c - int'(x);
      di   = 3'(dx);
      colb = '0;
      if (dx >= 0 && dx <= 4) begin
        colb = g[{di, 3'b000} +: 8];
      end
      for (int r = 0; r < 8; r++) begin
        j = int'(pgv) * 8 + r - int'(y);
        if (j >= 0 && j <= 7) begin
          m[c*8 + r] = colb[3'(j)];
        end
      end
    end
    return m;
  endfunction

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign page_ok   = int'(page_sel) < PAGE_COUNT;

  // The draw visits up to four words: two pages by two word columns, chosen
  // by the two bits of tgt. Words off the screen are skipped without a read or write.
  assign pg         = tgt[1] ? p0 + 7'sd1 : p0;
  assign wc         = tgt[0] ? w0 + 7'sd1 : w0;
  assign tgt_ok     = (pg >= 7'sd0) && (int'(pg) < PAGE_COUNT) &&
                      (wc >= 7'sd0) && (int'(wc) < WordsPerPage);
  assign draw_addr  = AW'(int'(pg) * WordsPerPage + int'(wc));
  assign flush_addr = AW'(int'(page_r) * WordsPerPage + int'(wcnt));
  assign last_word  = wcnt == WW'(WordsPerPage - 1);

  always_comb begin
    case (cmd_idx)
      3'd0:    cmd_byte = CMD_COL_ADDR;
      3'd1:    cmd_byte = COL_START;
      3'd2:    cmd_byte = 8'(WIDTH_PX - 1);
      3'd3:    cmd_byte = CMD_PAGE_ADDR;
      default: cmd_byte = {5'd0, page_r};
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(StoreWords - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_DRAW:  state_next = ST_DRAW_RD;
            FUNC_FLUSH: state_next = page_ok ? ST_FL_CMD : ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_RD: begin
        if (tgt_ok) begin
          state_next = ST_DRAW_WR;
        end else if (tgt == 2'd3) begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAW_WR: begin
        state_next = (tgt == 2'd3) ? ST_IDLE : ST_DRAW_RD;
      end
      ST_FL_CMD: begin
        if (slot_free && cmd_idx == 3'(CMD_COUNT - 1)) begin
          state_next = ST_FL_RD;
        end
      end
      ST_FL_RD: begin
        state_next = ST_FL_DATA;
      end
      ST_FL_DATA: begin
        if (slot_free) begin
          state_next = last_word ? ST_IDLE : ST_FL_RD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Store and output controls for each state.
  always_comb begin
    in_ready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = draw_addr;
    ram_wr_data = ram_rd_data | build_mask(glyph, x_r, y_r, pg, wc);
    ram_rd_en   = 1'b0;
    ram_rd_addr = draw_addr;
    out_load    = 1'b0;
    kind_next   = 1'b0;
    value_next  = {56'd0, cmd_byte};
    last_next   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DRAW_RD: begin
        ram_rd_en = tgt_ok;
      end
      ST_DRAW_WR: begin
        ram_wr_en = 1'b1;
      end
      ST_FL_CMD: begin
        out_load = slot_free;
      end
      ST_FL_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = flush_addr;
      end
      ST_FL_DATA: begin
        out_load   = slot_free;
        kind_next  = 1'b1;
        value_next = ram_rd_data;
        last_next  = last_word;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      tgt       <= '0;
      cmd_idx   <= '0;
      wcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        ST_CLEAR: begin
          clr_cnt <= (clr_cnt == AW'(StoreWords - 1)) ? '0 : clr_cnt + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            clr_cnt <= '0;
            tgt     <= '0;
            cmd_idx <= '0;
            wcnt    <= '0;
          end
        end
        ST_DRAW_RD: begin
          if (!tgt_ok) begin
            tgt <= tgt + 1'b1;
          end
        end
        ST_DRAW_WR: begin
          tgt <= tgt + 1'b1;
        end
        ST_FL_CMD: begin
          if (slot_free) begin
            cmd_idx <= cmd_idx + 1'b1;
          end
        end
        ST_FL_DATA: begin
          if (slot_free) begin
            wcnt <= wcnt + 1'b1;
          end
        end
        default: begin
          clr_cnt <= clr_cnt;
        end
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph  <= FONT_ROM[font_index(char_code)];
      x_r    <= x_pos;
      y_r    <= y_pos;
      p0     <= 7'(y_pos >>> 3);
      w0     <= 7'(x_pos >>> 3);
      page_r <= page_sel;
    end
    if (out_load) begin
      kind  <= kind_next;
      value <= value_next;
      last  <= last_next;
    end
  end

  // A run only ever ends on a data word.
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind)
    else $error("last flagged on a command byte");

  // Flushing only reads the store; nothing may change it meanwhile.
  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FL_CMD || state == ST_FL_RD || state == ST_FL_DATA) |-> !ram_wr_en)
    else $error("store written during a flush");

  // Every draw write merges data read in the cycle just before.
  a_draw_rmw: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW_WR |-> $past(ram_rd_en))
    else $error("draw write without a preceding read");

  // A result is produced only by the flush sequencer.
  a_load_in_flush: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_FL_CMD || state == ST_FL_DATA))
    else $error("output loaded outside a flush");

endmodule
